/* src/rep_pkg.sv */
// Shared constants and control types for the range partition block.
// Used by the interfaces, the controller, the datapath and the top level.
`default_nettype none

package rep_pkg;

    localparam int MAX_PARTS = 63;
    localparam int IDX_W     = 32;
    localparam int PART_W    = 6;
    // A range length can reach 2^32, so it needs one bit more than an index.
    localparam int LEN_W     = IDX_W + 1;
    // The divider retires one quotient bit per cycle.
    localparam int DIV_STEPS = LEN_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef struct packed {
        logic load;
        logic div_step;
        logic advance;
    } ctrl_cmd_t;

    typedef struct packed {
        logic err;
        logic last;
    } dp_status_t;

endpackage

`default_nettype wire

/* src/rep_if.sv */
// Handshake channels of the range partition block: ranges in, boundaries out.
// Depends on rep_pkg for field widths.
`default_nettype none

interface rep_range_if;
    import rep_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] range_start;
    logic [IDX_W-1:0] range_end;

    modport source (output valid, output range_start, output range_end, input ready);
    modport sink (input valid, input range_start, input range_end, output ready);
endinterface

interface rep_bound_if;
    import rep_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] boundary;
    logic             last_boundary;
    logic             range_error;

    modport source (output valid, output boundary, output last_boundary,
                    output range_error, input ready);
    modport sink (input valid, input boundary, input last_boundary,
                  input range_error, output ready);
endinterface

`default_nettype wire

/* src/rep_datapath.sv */
// Datapath: part count register, bit-serial divider and boundary accumulator.
// Depends on rep_pkg; driven by commands from rep_controller.
`default_nettype none

module rep_datapath (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [rep_pkg::PART_W-1:0] cfg_data,
    input  wire logic [rep_pkg::IDX_W-1:0] range_start,
    input  wire logic [rep_pkg::IDX_W-1:0] range_end,
    input  rep_pkg::ctrl_cmd_t             cmd,
    output rep_pkg::dp_status_t            status,
    output logic [rep_pkg::IDX_W-1:0]      boundary,
    output logic                           range_error
);
    import rep_pkg::*;

    logic [PART_W-1:0] part_count_reg;
    logic [PART_W-1:0] parts;
    logic [LEN_W-1:0]  len;
    logic [PART_W-1:0] n_sel;
    logic              bad_range;

    logic              err_reg;
    logic [IDX_W-1:0]  bnd_reg;
    logic [LEN_W-1:0]  quo_reg;
    logic [PART_W-1:0] rem_reg;
    logic [PART_W-1:0] n_reg;
    logic [PART_W-1:0] k_reg;

    logic [PART_W:0]   trial;
    logic              fits;
    logic [PART_W:0]   diff;
    logic              extra;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_count_reg <= PART_W'(1);
        end
        else if (cfg_we)
        begin
            part_count_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (part_count_reg == '0)
        begin
            parts = PART_W'(1);
        end
        else if (part_count_reg > PART_W'(MAX_PARTS))
        begin
            parts = PART_W'(MAX_PARTS);
        end
        else
        begin
            parts = part_count_reg;
        end
        bad_range = range_end < range_start;
        len       = {1'b0, range_end} - {1'b0, range_start} + LEN_W'(1);
        // Never more parts than there are indices in the range.
        n_sel     = (len < LEN_W'(parts)) ? len[PART_W-1:0] : parts;
    end

    // One restoring division step: the dividend shifts out of the quotient
    // register while quotient bits shift in behind it.
    always_comb
    begin
        trial = {rem_reg, quo_reg[LEN_W-1]};
        fits  = trial >= {1'b0, n_reg};
        diff  = trial - {1'b0, n_reg};
        extra = k_reg < rem_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            err_reg <= bad_range;
            bnd_reg <= bad_range ? '0 : range_start;
            quo_reg <= len;
            rem_reg <= '0;
            n_reg   <= n_sel;
            k_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= fits ? diff[PART_W-1:0] : trial[PART_W-1:0];
            quo_reg <= {quo_reg[LEN_W-2:0], fits};
        end
        else if (cmd.advance)
        begin
            // The first remainder-many parts are one index longer.
            bnd_reg <= bnd_reg + quo_reg[IDX_W-1:0] + IDX_W'(extra);
            k_reg   <= k_reg + PART_W'(1);
        end
    end

    assign status.err   = err_reg;
    assign status.last  = err_reg || (k_reg == n_reg);
    assign boundary     = bnd_reg;
    assign range_error  = err_reg;

endmodule

`default_nettype wire

/* src/rep_controller.sv */
// Controller state machine: accepts a range, runs the divider, emits boundaries.
// Depends on rep_pkg for the command and status types.
`default_nettype none

module rep_controller (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  rep_pkg::dp_status_t status,
    output rep_pkg::ctrl_cmd_t  cmd
);
    import rep_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (in_valid)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    // A reversed range has nothing to divide.
                    if (status.err || cnt_reg == CNT_W'(DIV_STEPS - 1))
                    begin
                        state_reg <= ST_EMIT;
                        cnt_reg   <= '0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_EMIT:
                begin
                    if (out_ready && status.last)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        in_ready     = state_reg == ST_IDLE;
        out_valid    = state_reg == ST_EMIT;
        cmd.load     = in_ready && in_valid;
        cmd.div_step = (state_reg == ST_DIV) && !status.err;
        cmd.advance  = out_valid && out_ready && !status.last;
    end

endmodule

`default_nettype wire

/* src/range_equal_partition_core.sv */
// Top level of the range partition block: joins controller and datapath.
// Depends on rep_pkg, rep_if, rep_controller and rep_datapath.
//
//   channel     dir  handshake     payload
//   ranges      in   valid/ready   range_start, range_end
//   boundaries  out  valid/ready   boundary, last_boundary, range_error
//   cfg         in   cfg_we        cfg_data (part_count)
//
// An item is accepted, the divider then retires one quotient bit per cycle, and
// then the n+1 boundaries are emitted as the receiver takes them.
// A reversed range skips the division steps and has a single result.
// The boundary registers hold each result until it is taken; the next range
// is accepted after the last boundary leaves. Reset sets part_count to 1.
`default_nettype none

module range_equal_partition_core (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [rep_pkg::PART_W-1:0] cfg_data,
    rep_range_if.sink                      ranges,
    rep_bound_if.source                    boundaries
);
    import rep_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    rep_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ranges.valid),
        .in_ready  (ranges.ready),
        .out_valid (boundaries.valid),
        .out_ready (boundaries.ready),
        .status    (status),
        .cmd       (cmd)
    );

    rep_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .range_start (ranges.range_start),
        .range_end   (ranges.range_end),
        .cmd         (cmd),
        .status      (status),
        .boundary    (boundaries.boundary),
        .range_error (boundaries.range_error)
    );

    assign boundaries.last_boundary = status.last;

endmodule

`default_nettype wire

/* dv/range_equal_partition_core_test.sv */
// Self-checking testbench for range_equal_partition_core: sends index ranges,
// predicts every part boundary and compares each emitted boundary in order.
// Depends on rep_pkg, rep_if and the range_equal_partition_core RTL.

module range_equal_partition_core_test;
    import rep_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0] boundary;
        logic             last;
        logic             err;
    } boundary_t;

    localparam longint unsigned RUN_LIMIT = 100_000_000;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [PART_W-1:0] cfg_data;

    rep_range_if range_ch ();
    rep_bound_if bound_ch ();

    range_equal_partition_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .ranges     (range_ch),
        .boundaries (bound_ch)
    );

    boundary_t         pending_bounds[$];
    logic [PART_W-1:0] part_count_q = PART_W'(1);
    int                error_count  = 0;
    // When set, neither side idles: no sender gaps and no receiver stalls.
    bit                steady       = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("range_equal_partition_core_test NOT OK");
        $finish;
    end

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic longint unsigned effective_parts();
        if (part_count_q == 0)
            return 64'd1;
        if (part_count_q > MAX_PARTS)
            return 64'(MAX_PARTS);
        return 64'(part_count_q);
    endfunction

    // Queues the boundaries of [s, e] split into nearly equal parts, or one error item if e < s.
    function automatic void partition_range(input logic [IDX_W-1:0] s,
                                            input logic [IDX_W-1:0] e);
        longint unsigned len, n, q, r, extra, b;
        boundary_t       item;
        if (e < s)
        begin
            item.boundary = '0;
            item.last     = 1'b1;
            item.err      = 1'b1;
            pending_bounds = {pending_bounds, item};
            return;
        end
        len = longint'(e) - longint'(s) + 1;
        n   = (effective_parts() < len) ? effective_parts() : len;
        q   = len / n;
        r   = len % n;
        for (longint unsigned k = 0; k <= n; k++)
        begin
            extra         = (k < r) ? k : r;
            b             = longint'(s) + k * q + extra;
            item.boundary = b[IDX_W-1:0];
            item.last     = (k == n);
            item.err      = 1'b0;
            pending_bounds = {pending_bounds, item};
        end
    endfunction

    task automatic send_range(input logic [IDX_W-1:0] s, input logic [IDX_W-1:0] e);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            range_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        range_ch.valid       <= 1'b1;
        range_ch.range_start <= s;
        range_ch.range_end   <= e;
        do
            @(posedge clk);
        while (!range_ch.ready);
        partition_range(s, e);
    endtask

    // Drops valid and waits until every queued boundary has come out.
    task automatic settle();
        range_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_bounds.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_part_count(input logic [PART_W-1:0] value);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we       <= 1'b0;
        part_count_q  = value;
    endtask

    // Receiver side: random stalls on ready, and a check of every item taken.
    initial
    begin
        int        stall_left;
        boundary_t want;
        stall_left     = 0;
        bound_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (bound_ch.valid && bound_ch.ready)
            begin
                if (pending_bounds.size() == 0)
                    report_error($sformatf("boundary %h with nothing expected",
                                           bound_ch.boundary));
                else
                begin
                    want = pending_bounds.pop_front();
                    if (bound_ch.boundary !== want.boundary)
                        report_error($sformatf("boundary %h, expected %h",
                                               bound_ch.boundary, want.boundary));
                    if (bound_ch.last_boundary !== want.last)
                        report_error($sformatf("last_boundary %b, expected %b at %h",
                                               bound_ch.last_boundary, want.last,
                                               want.boundary));
                    if (bound_ch.range_error !== want.err)
                        report_error($sformatf("range_error %b, expected %b at %h",
                                               bound_ch.range_error, want.err,
                                               want.boundary));
                end
            end
            if (stall_left > 0)
                stall_left--;
            else if (!steady && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            bound_ch.ready <= (stall_left == 0);
        end
    end

    task automatic test_reset_default();
        send_range(32'd0, 32'd0);
        send_range(32'd5, 32'd9);
        send_range(32'd0, 32'hFFFF_FFFE);
        send_range(32'hFFFF_FFFE, 32'hFFFF_FFFE);
        // Full index space: the length is 2^32 and the last boundary wraps to 0.
        send_range(32'd0, 32'hFFFF_FFFF);
        send_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_reversed_range();
        send_range(32'd1, 32'd0);
        send_range(32'hFFFF_FFFF, 32'd0);
        send_range(32'd100, 32'd99);
    endtask

    task automatic test_part_count_limits();
        write_part_count(6'd63);
        send_range(32'd0, 32'd62);
        send_range(32'd0, 32'd63);
        send_range(32'd1000, 32'd1009);
        send_range(32'd0, 32'hFFFF_FFFF);
        send_range(32'h8000_0000, 32'hFFFF_FFFF);
        send_range(32'd7, 32'd3);
        // A count of zero behaves as a single part.
        write_part_count(6'd0);
        send_range(32'd3, 32'd7);
        send_range(32'd0, 32'hFFFF_FFFE);
        write_part_count(6'd2);
        send_range(32'd0, 32'd4);
        send_range(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        write_part_count(6'd7);
        send_range(32'd10, 32'd20);
        send_range(32'hFFFF_FFF0, 32'hFFFF_FFFF);
    endtask

    task automatic make_range(output logic [IDX_W-1:0] s, output logic [IDX_W-1:0] e);
        logic [IDX_W-1:0] a, b;
        longint unsigned  len;
        int               sel;
        sel = $urandom_range(0, 99);
        a   = $urandom;
        b   = $urandom;
        len = 64'($urandom_range(1, 32'(2 * effective_parts() + 3)));
        if (sel < 10)
        begin
            if (a == b)
                b = a ^ 32'd1;
            s = (a > b) ? a : b;
            e = (a > b) ? b : a;
        end
        else if (sel < 55)
        begin
            s = a;
            if (longint'(s) + len - 1 > 64'hFFFF_FFFF)
                s = IDX_W'(64'hFFFF_FFFF - (len - 1));
            e = s + IDX_W'(len - 1);
        end
        else if (sel < 70)
        begin
            e = 32'hFFFF_FFFF - $urandom_range(0, 2);
            s = e - IDX_W'(len - 1);
        end
        else if (sel < 75)
        begin
            s = $urandom_range(0, 3);
            e = (b < s) ? s : b;
        end
        else
        begin
            s = (a < b) ? a : b;
            e = (a < b) ? b : a;
        end
    endtask

    task automatic test_random_ranges();
        logic [IDX_W-1:0]  s, e;
        logic [PART_W-1:0] count;
        for (int phase = 0; phase < 12; phase++)
        begin
            if (phase == 0)
                count = 6'd63;
            else if (phase == 1)
                count = 6'd0;
            else if (phase == 2)
                count = 6'd1;
            else
                count = PART_W'($urandom_range(0, 63));
            write_part_count(count);
            steady = (phase % 4 == 3);
            for (int i = 0; i < 40; i++)
            begin
                make_range(s, e);
                send_range(s, e);
            end
            steady = 1'b0;
        end
    endtask

    initial
    begin
        range_ch.valid       = 1'b0;
        range_ch.range_start = '0;
        range_ch.range_end   = '0;
        cfg_we               = 1'b0;
        cfg_data             = '0;
        rst_n                = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_default();
        test_reversed_range();
        test_part_count_limits();
        test_random_ranges();

        settle();
        repeat (50) @(posedge clk);
        if (pending_bounds.size() != 0)
            report_error($sformatf("%0d boundaries never arrived", pending_bounds.size()));
        if (error_count == 0)
            $display("range_equal_partition_core_test OK");
        else
            $display("range_equal_partition_core_test NOT OK");
        $finish;
    end

endmodule
